FILE: rtl/b64d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

    // The padding character counts as zero but shortens the final group.
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Byte counts that one group can produce.
    localparam logic [1:0] BYTES_ONE   = 2'd1;
    localparam logic [1:0] BYTES_TWO   = 2'd2;
    localparam logic [1:0] BYTES_THREE = 2'd3;

    // Positions within a group of four characters.
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_FOURTH = 2'd3;

    // One finished group, handed from the front to the back.
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  n_bytes;
        logic        msg_end;
    } t_group_entry;

    // Status of the queue between the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    // Character to 6-bit value; standard and URL-safe alphabets both accepted.
    function automatic logic [5:0] map_char(input logic [7:0] c);
        logic [5:0] v;
        v = 6'd0;
        unique case (c) inside
            [8'h41:8'h5A]:        v = 6'(c - 8'h41);
            [8'h61:8'h7A]:        v = 6'(c - 8'h61 + 8'd26);
            [8'h30:8'h39]:        v = 6'(c - 8'h30 + 8'd52);
            8'h2B, 8'h2D, 8'h2E:  v = 6'd62;
            8'h2F, 8'h5F, 8'h2C:  v = 6'd63;
            default:              v = 6'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/b64d_front.sv
`timescale 1ns / 1ps
`default_nettype none

module b64d_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire logic [7:0]            i_char_code,
    input  wire logic                  i_end_of_text,
    output logic                       o_push,
    output b64d_pkg::t_group_entry     o_entry
);
    import b64d_pkg::*;

    logic [17:0] r_sextets, n_sextets;
    logic [1:0]  r_pos, n_pos;
    logic        r_third_pad, n_third_pad;

    logic [5:0]  value;
    logic        is_pad;
    logic [23:0] joined;

    assign value  = map_char(i_char_code);
    assign is_pad = (i_char_code == PAD_CHAR);
    assign joined = {r_sextets, value};

    // Classify the character: gather it, or close the group and emit an entry.
    always_comb begin
        n_sextets       = r_sextets;
        n_pos           = r_pos;
        n_third_pad     = r_third_pad;
        o_push          = 1'b0;
        o_entry.word    = joined;
        o_entry.n_bytes = BYTES_THREE;
        o_entry.msg_end = i_end_of_text;
        if (i_accept) begin
            if (!i_end_of_text && r_pos != POS_FOURTH) begin
                n_sextets = joined[17:0];
                n_pos     = r_pos + 2'd1;
                if (r_pos == POS_THIRD) begin
                    n_third_pad = is_pad;
                end
            end else begin
                o_push      = 1'b1;
                n_sextets   = '0;
                n_pos       = POS_FIRST;
                n_third_pad = 1'b0;
                if (i_end_of_text) begin
                    // Left-align the partial group within the 24-bit word.
                    unique case (r_pos)
                        POS_FIRST: begin
                            o_entry.word    = {value, 18'd0};
                            o_entry.n_bytes = BYTES_ONE;
                        end
                        POS_SECOND: begin
                            o_entry.word    = {joined[11:0], 12'd0};
                            o_entry.n_bytes = BYTES_ONE;
                        end
                        POS_THIRD: begin
                            o_entry.word    = {joined[17:0], 6'd0};
                            o_entry.n_bytes = is_pad ? BYTES_ONE : BYTES_TWO;
                        end
                        default: begin
                            o_entry.word = joined;
                            if (!is_pad) begin
                                o_entry.n_bytes = BYTES_THREE;
                            end else begin
                                o_entry.n_bytes = r_third_pad ? BYTES_ONE : BYTES_TWO;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // Group state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sextets   <= '0;
            r_pos       <= POS_FIRST;
            r_third_pad <= 1'b0;
        end else begin
            r_sextets   <= n_sextets;
            r_pos       <= n_pos;
            r_third_pad <= n_third_pad;
        end
    end

    // A message's last character always leaves the group state clear.
    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_end_of_text) |=> (r_pos == POS_FIRST && r_sextets == 18'd0))
        else $error("group state not cleared after end of text");

endmodule

`default_nettype wire

FILE: rtl/b64d_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module b64d_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire b64d_pkg::t_group_entry i_entry,
    input  wire logic                  i_pop,
    output b64d_pkg::t_group_entry     o_entry,
    output b64d_pkg::t_queue_status    o_status
);
    import b64d_pkg::*;

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    t_group_entry      r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [FILL_W-1:0] r_fill;

    assign o_status.full  = (r_fill == FILL_W'(DEPTH));
    assign o_status.empty = (r_fill == '0);
    assign o_entry        = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("queue read while empty");

endmodule

`default_nettype wire

FILE: rtl/b64d_back.sv
`timescale 1ns / 1ps
`default_nettype none

module b64d_back (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire b64d_pkg::t_group_entry i_entry,
    input  wire b64d_pkg::t_queue_status i_status,
    output logic                        o_pop,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [7:0]                  o_data_byte,
    output logic                        o_run_last,
    output logic                        o_message_last
);
    import b64d_pkg::*;

    logic        r_busy;
    logic [23:0] r_word;
    logic [1:0]  r_count;
    logic [1:0]  r_idx;
    logic        r_msg_end;
    logic        final_byte;

    assign final_byte     = ((r_idx + 2'd1) == r_count);
    assign o_valid        = r_busy;
    assign o_run_last     = final_byte;
    assign o_message_last = final_byte && r_msg_end;

    // Pick the byte of the current group, most significant first.
    always_comb begin
        unique case (r_idx)
            2'd0:    o_data_byte = r_word[23:16];
            2'd1:    o_data_byte = r_word[15:8];
            default: o_data_byte = r_word[7:0];
        endcase
    end

    // Take a new group when idle or as the last byte of the current one leaves.
    assign o_pop = !i_status.empty && (!r_busy || (i_ready && final_byte));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy && i_ready) begin
            if (final_byte) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word    <= i_entry.word;
            r_count   <= i_entry.n_bytes;
            r_msg_end <= i_entry.msg_end;
        end
    end

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_count != 2'd0 && r_idx < r_count))
        else $error("byte index outside group");

endmodule

`default_nettype wire

FILE: rtl/base64_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_char_code, i_end_of_text
// output    out        o_out_valid / i_out_ready  o_data_byte, o_run_last, o_message_last
//
// One character is taken per cycle while o_in_ready is high; the front holds it in
// the group state. A closed group goes into a queue of QUEUE_DEPTH entries; the back
// loads it from there and sends one byte per cycle while i_out_ready is high.
// o_in_ready is low only while the queue is full.
// Reset is synchronous, active low, and clears group, queue and back state.

module base64_decoder_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_char_code,
    input  wire logic       i_end_of_text,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_data_byte,
    output logic            o_run_last,
    output logic            o_message_last
);
    import b64d_pkg::*;

    t_group_entry  push_entry, pop_entry;
    t_queue_status q_status;
    logic          push, pop, in_accept;

    assign o_in_ready = !q_status.full;
    assign in_accept  = i_in_valid && o_in_ready;

    b64d_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_char_code   (i_char_code),
        .i_end_of_text (i_end_of_text),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_entry  (pop_entry),
        .o_status (q_status)
    );

    b64d_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_entry        (pop_entry),
        .i_status       (q_status),
        .o_pop          (pop),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_data_byte    (o_data_byte),
        .o_run_last     (o_run_last),
        .o_message_last (o_message_last)
    );

endmodule

`default_nettype wire
